/* sv/upd_pkg.sv */
`timescale 1ns / 1ps
// upd_pkg: shared types, constants and the hex digit decode for the percent decoder
// depends on nothing; imported by url_percent_decoder

package upd_pkg;

   localparam logic [7:0] PctChar   = 8'h25;
   localparam logic [7:0] PlusChar  = 8'h2B;
   localparam logic [7:0] SpaceChar = 8'h20;

   // result queue sizing
   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   // most results one item can cause
   localparam int MaxResults = 3;
   localparam int RunIdxW    = $clog2(MaxResults);

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       string_end;
   } rsp_type;

   // escape tracking, one-hot
   typedef enum logic [2:0] {
      PH_IDLE  = 3'b001,
      PH_PCT   = 3'b010,
      PH_DIGIT = 3'b100
   } phase_type;

   // results of one item, stored as one queue entry
   typedef struct packed {
      logic [RunIdxW-1:0]               cnt;
      logic [MaxResults-1:0][7:0]       data;
      logic                             eos;
   } group_type;

   // bit 4 set: not a hex digit, else bits 3:0 hold the nibble
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] r;
      r = 5'h10;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b0, c[3:0]};
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         r = {1'b0, c[3:0] + 4'd9};
      end
      return r;
   endfunction

endpackage

/* sv/url_percent_decoder.sv */
`timescale 1ns / 1ps
// url_percent_decoder: streaming percent decoder, one encoded byte per item
// depends on upd_pkg
//
// usage:
//  - req channel (valid/ready) carries one encoded byte and a last-of-string flag
//  - rsp channel (valid/ready) carries decoded bytes, each with run_last (last
//    result of its input item) and string_end (final decoded byte of the string)
//  - csr_wr_en / csr_wr_data set the form-mode bit ('+' decodes to a space);
//    write only while the block is idle
//  - an item's results are worked out in the cycle it is accepted and stored as
//    one entry of a four-entry result queue; when the queue is empty, the first
//    result shows on rsp the next cycle
//  - throughput is one item per cycle as long as each causes at most one result
//    and rsp_ready stays high; a failed escape gives three results that drain
//    one by one, and the queue depth absorbs that while the input keeps flowing
//  - req_ready depends only on the queue fill count, never on rsp_ready
//  - when the receiver stalls the queue fills and req_ready drops once all four
//    entries are taken; nothing is lost or repeated
//  - reset empties the queue, leaves the escape state idle and clears the
//    form-mode bit

module url_percent_decoder (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  upd_pkg::req_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output upd_pkg::rsp_type rsp_payload,
   input  logic            csr_wr_en,
   input  logic            csr_wr_data
);
   import upd_pkg::*;

   // configuration
   logic form_mode_ff;

   // escape state
   phase_type  phase_ff, phase_in;
   logic [7:0] held_ff, held_in;

   // result queue
   group_type              queue_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QueueCntW-1:0]   count_ff;
   logic [RunIdxW-1:0]     run_ff;

   group_type  grp_in;
   group_type  head;
   logic [4:0] hi_nib, lo_nib;
   logic       req_take, rsp_take, push, pop, head_done;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   // decode: results of the incoming item and the next escape state
   always_comb begin
      hi_nib   = hex_value(held_ff);
      lo_nib   = hex_value(req_payload.in_byte);
      grp_in   = '0;
      grp_in.eos = req_payload.in_last;
      phase_in = phase_ff;
      held_in  = held_ff;
      unique case (phase_ff)
         PH_PCT: begin
            if (req_payload.in_last) begin
               // short escape at end of string, flush verbatim
               grp_in.cnt     = RunIdxW'(2);
               grp_in.data[0] = PctChar;
               grp_in.data[1] = req_payload.in_byte;
               phase_in       = PH_IDLE;
            end else begin
               held_in  = req_payload.in_byte;
               phase_in = PH_DIGIT;
            end
         end
         PH_DIGIT: begin
            if (!hi_nib[4] && !lo_nib[4]) begin
               grp_in.cnt     = RunIdxW'(1);
               grp_in.data[0] = {hi_nib[3:0], lo_nib[3:0]};
            end else begin
               // failed escape, all three bytes verbatim
               grp_in.cnt     = RunIdxW'(3);
               grp_in.data[0] = PctChar;
               grp_in.data[1] = held_ff;
               grp_in.data[2] = req_payload.in_byte;
            end
            phase_in = PH_IDLE;
         end
         default: begin
            phase_in = PH_IDLE;
            if (req_payload.in_byte == PctChar && !req_payload.in_last) begin
               phase_in = PH_PCT;
            end else if (req_payload.in_byte == PlusChar && form_mode_ff) begin
               grp_in.cnt     = RunIdxW'(1);
               grp_in.data[0] = SpaceChar;
            end else begin
               grp_in.cnt     = RunIdxW'(1);
               grp_in.data[0] = req_payload.in_byte;
            end
         end
      endcase
   end

   // queue control
   assign req_ready = (count_ff < QueueCntW'(QueueDepth));
   assign head      = queue_ff[rd_ptr_ff];
   assign rsp_valid = (count_ff != '0);
   assign head_done = (run_ff == head.cnt - RunIdxW'(1));
   assign push      = req_take && (grp_in.cnt != '0);
   assign pop       = rsp_take && head_done;

   always_comb begin
      rsp_payload.out_byte   = head.data[run_ff];
      rsp_payload.run_last   = head_done;
      rsp_payload.string_end = head_done && head.eos;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         form_mode_ff <= 1'b0;
         phase_ff     <= PH_IDLE;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         run_ff       <= '0;
      end else begin
         if (csr_wr_en) begin
            form_mode_ff <= csr_wr_data;
         end
         if (req_take) begin
            phase_ff <= phase_in;
         end
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QueuePtrW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QueuePtrW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + QueueCntW'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - QueueCntW'(1);
         end
         if (rsp_take) begin
            run_ff <= head_done ? '0 : run_ff + RunIdxW'(1);
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         held_ff <= held_in;
      end
      if (push) begin
         queue_ff[wr_ptr_ff] <= grp_in;
      end
   end

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QueueCntW'(QueueDepth))
      else $error("result queue count beyond depth");

   a_run_in_group: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (run_ff < head.cnt))
      else $error("run index outside head group");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.string_end) |-> rsp_payload.run_last)
      else $error("string_end without run_last");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_payload.in_last) |=> (phase_ff == PH_IDLE))
      else $error("escape state not idle after end of string");

   a_run_resets: assert property (@(posedge clock) disable iff (reset)
      pop |=> (run_ff == '0))
      else $error("run index not cleared after group drained");

endmodule
